>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertions on clk, masked while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> src/wsr_pkg.sv
// ----------------------------------------------------------------------------
// wsr_pkg
// fixed-point types, constants and arithmetic helpers for the wilkes
// square root pipeline (signed q4.30 internal format)
// ----------------------------------------------------------------------------
package wsr_pkg;

  localparam int ITERATIONS   = 5;
  localparam int FRAC_BITS    = 30;
  localparam int HI_W         = 5;
  localparam int Q_W          = HI_W + FRAC_BITS;
  localparam int W_W          = Q_W + 3;
  localparam int SUM_W        = 2 * HI_W + FRAC_BITS;
  localparam int ROOT_W       = 32;
  localparam int ROUND_STAGES = 5;
  localparam int FINAL_STAGES = 3;
  localparam int STAGES       = 1 + ROUND_STAGES * ITERATIONS + FINAL_STAGES + 1;
  localparam int LAST_STAGE   = STAGES - 1;

  typedef logic signed [Q_W-1:0]         q_t;
  typedef logic signed [W_W-1:0]         w_t;
  typedef logic [Q_W-1:0]                mag_t;
  typedef logic [SUM_W-1:0]              sum_t;
  typedef logic [2*HI_W-2:0]             hh_t;
  typedef logic [HI_W+FRAC_BITS-2:0]     cr_t;
  typedef logic [2*FRAC_BITS-1:0]        llp_t;
  typedef logic [ROOT_W-1:0]             root_t;

  localparam w_t   W_ONE   = w_t'(64'sd1 <<< FRAC_BITS);
  localparam w_t   W_THREE = w_t'(64'sd3 <<< FRAC_BITS);
  localparam w_t   W_FOUR  = w_t'(64'sd4 <<< FRAC_BITS);
  localparam w_t   W_MAX   = w_t'((64'sd1 <<< (Q_W - 1)) - 64'sd1);
  localparam w_t   W_MIN   = w_t'(-(64'sd1 <<< (Q_W - 1)));
  localparam sum_t POS_LIM = sum_t'((64'd1 << (Q_W - 1)) - 64'd1);
  localparam sum_t NEG_LIM = sum_t'(64'd1 << (Q_W - 1));
  localparam root_t ROOT_SAT = '1;

  // partial products of a sign-magnitude multiply, split at the binary point
  typedef struct packed {
    logic                 neg;
    hh_t                  hh;
    cr_t                  hl;
    cr_t                  lh;
    logic [FRAC_BITS-1:0] ll;
  } pp_t;

  typedef struct packed {
    q_t a;
    q_t b;
  } ab_t;

  typedef struct packed {
    q_t a;
    q_t b;
    q_t fac;
    q_t qtr;
  } prep_t;

  typedef struct packed {
    pp_t pa;
    pp_t pb;
    q_t  qtr;
  } m1_t;

  typedef struct packed {
    q_t a;
    q_t sq;
    q_t qtr;
  } s1_t;

  typedef struct packed {
    pp_t pq;
    q_t  a;
  } m2_t;

  typedef struct packed {
    q_t a;
    q_t fac;
  } fprep_t;

  function automatic q_t q_sat(w_t v);
    if (v > W_MAX) return q_t'(W_MAX);
    if (v < W_MIN) return q_t'(W_MIN);
    return q_t'(v);
  endfunction

  function automatic q_t to_q(root_t x);
    return signed'(mag_t'(x));
  endfunction

  // 1 - b/2, halving truncates toward zero
  function automatic q_t wilkes_factor(q_t b);
    w_t bw;
    w_t h;
    bw = w_t'(b);
    h  = b[Q_W-1] ? ((bw + w_t'(1)) >>> 1) : (bw >>> 1);
    return q_sat(W_ONE - h);
  endfunction

  // (b - 3)/4, truncating toward zero
  function automatic q_t quarter(q_t b);
    q_t s;
    w_t sw;
    s  = q_sat(w_t'(b) - W_THREE);
    sw = w_t'(s);
    if (s[Q_W-1]) sw = (sw + w_t'(3)) >>> 2;
    else          sw = sw >>> 2;
    return q_t'(sw);
  endfunction

  function automatic mag_t magnitude(q_t x);
    mag_t u;
    u = mag_t'(x);
    return x[Q_W-1] ? (mag_t'(0) - u) : u;
  endfunction

  function automatic pp_t mul_split(q_t x, q_t y);
    mag_t mx;
    mag_t my;
    llp_t lo_prod;
    pp_t  p;
    mx      = magnitude(x);
    my      = magnitude(y);
    lo_prod = llp_t'(mx[FRAC_BITS-1:0]) * llp_t'(my[FRAC_BITS-1:0]);
    p.neg   = x[Q_W-1] ^ y[Q_W-1];
    p.hh    = hh_t'(mx[Q_W-1:FRAC_BITS]) * hh_t'(my[Q_W-1:FRAC_BITS]);
    p.hl    = cr_t'(mx[Q_W-1:FRAC_BITS]) * cr_t'(my[FRAC_BITS-1:0]);
    p.lh    = cr_t'(mx[FRAC_BITS-1:0]) * cr_t'(my[Q_W-1:FRAC_BITS]);
    p.ll    = lo_prod[2*FRAC_BITS-1:FRAC_BITS];
    return p;
  endfunction

  // truncated product magnitude, sign applied, saturated to q4.30
  function automatic q_t mul_sum(pp_t p);
    sum_t q;
    mag_t m;
    q = sum_t'({p.hh, p.ll}) + sum_t'(p.hl) + sum_t'(p.lh);
    if (p.neg) begin
      if (q > NEG_LIM) return q_t'(W_MIN);
      m = mag_t'(0) - q[Q_W-1:0];
      return signed'(m);
    end
    if (q > POS_LIM) return q_t'(W_MAX);
    return signed'(q[Q_W-1:0]);
  endfunction

endpackage

>>> src/wsr_if.sv
// ----------------------------------------------------------------------------
// wsr_in_if / wsr_out_if
// valid/ready channels carrying radicand words in and root words out
// ----------------------------------------------------------------------------
interface wsr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink (input valid, input radicand, output ready);
endinterface

interface wsr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] root;
  logic        clamped;

  modport source (output valid, output root, output clamped, input ready);
  modport sink (input valid, input root, input clamped, output ready);
endinterface

>>> src/wilkes_square_root_top.sv
// ----------------------------------------------------------------------------
// wilkes_square_root_top
// Takes one unsigned q2.30 radicand word per cycle while ready is high and
// returns its square root by the multiplication-only wilkes iteration, with
// a clamp flag when the estimate leaves [0,4). Sustained rate is one word
// per clock while the sink does not stall. After a seed stage, each round
// takes five stages (prepare factors, partial products, sum, partial
// products, sum), then final factor, product, sum and output stages; each
// 35x35 product is split into one 30x30 and three narrow multiplies, then a sum stage.
// A one-word skid register at the output lets the pipeline take one more
// word after the sink stalls; while the skid is full the whole pipeline
// holds and ready is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wilkes_square_root_top (
  input logic        clk,
  input logic        rst,
  wsr_in_if.sink     sqin,
  wsr_out_if.source  sqout
);

  logic [wsr_pkg::STAGES-1:0] v;
  logic                       en;
  logic                       sk_v;
  wsr_pkg::root_t             sk_root;
  logic                       sk_clamped;
  wsr_pkg::root_t             out_root;
  logic                       out_clamped;
  wsr_pkg::root_t             root_next;
  logic                       clamped_next;
  wsr_pkg::q_t                seed_a;

  wsr_pkg::ab_t   ab [wsr_pkg::ITERATIONS+1];
  wsr_pkg::prep_t pr [wsr_pkg::ITERATIONS];
  wsr_pkg::m1_t   m1 [wsr_pkg::ITERATIONS];
  wsr_pkg::s1_t   s1 [wsr_pkg::ITERATIONS];
  wsr_pkg::m2_t   m2 [wsr_pkg::ITERATIONS];
  wsr_pkg::fprep_t fp;
  wsr_pkg::pp_t    fm;
  wsr_pkg::q_t     fs;

  assign en         = !sk_v;
  assign sqin.ready = en;
  assign seed_a     = wsr_pkg::to_q(sqin.radicand);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[wsr_pkg::STAGES-2:0], sqin.valid};
    end
  end

  // seed a = x, b = x - 1
  always_ff @(posedge clk) begin
    if (en) begin
      ab[0].a <= seed_a;
      ab[0].b <= wsr_pkg::q_sat(wsr_pkg::w_t'(seed_a) - wsr_pkg::W_ONE);
    end
  end

  for (genvar r = 0; r < wsr_pkg::ITERATIONS; r++) begin : g_round
    always_ff @(posedge clk) begin
      if (en) begin
        pr[r].a    <= ab[r].a;
        pr[r].b    <= ab[r].b;
        pr[r].fac  <= wsr_pkg::wilkes_factor(ab[r].b);
        pr[r].qtr  <= wsr_pkg::quarter(ab[r].b);

        m1[r].pa   <= wsr_pkg::mul_split(pr[r].a, pr[r].fac);
        m1[r].pb   <= wsr_pkg::mul_split(pr[r].b, pr[r].b);
        m1[r].qtr  <= pr[r].qtr;

        s1[r].a    <= wsr_pkg::mul_sum(m1[r].pa);
        s1[r].sq   <= wsr_pkg::mul_sum(m1[r].pb);
        s1[r].qtr  <= m1[r].qtr;

        m2[r].pq   <= wsr_pkg::mul_split(s1[r].sq, s1[r].qtr);
        m2[r].a    <= s1[r].a;

        ab[r+1].a  <= m2[r].a;
        ab[r+1].b  <= wsr_pkg::mul_sum(m2[r].pq);
      end
    end
  end

  // final a = a * (1 - b/2), then clamp
  always_comb begin
    if (fs[wsr_pkg::Q_W-1]) begin
      root_next    = '0;
      clamped_next = 1'b1;
    end else if (wsr_pkg::w_t'(fs) >= wsr_pkg::W_FOUR) begin
      root_next    = wsr_pkg::ROOT_SAT;
      clamped_next = 1'b1;
    end else begin
      root_next    = fs[wsr_pkg::ROOT_W-1:0];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fp.a        <= ab[wsr_pkg::ITERATIONS].a;
      fp.fac      <= wsr_pkg::wilkes_factor(ab[wsr_pkg::ITERATIONS].b);
      fm          <= wsr_pkg::mul_split(fp.a, fp.fac);
      fs          <= wsr_pkg::mul_sum(fm);
      out_root    <= root_next;
      out_clamped <= clamped_next;
    end
  end

  // skid word catches the output when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      sk_v <= 1'b0;
    end else if (sk_v) begin
      if (sqout.ready) sk_v <= 1'b0;
    end else if (v[wsr_pkg::LAST_STAGE] && !sqout.ready) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_v) begin
      sk_root    <= out_root;
      sk_clamped <= out_clamped;
    end
  end

  assign sqout.valid   = sk_v || v[wsr_pkg::LAST_STAGE];
  assign sqout.root    = sk_v ? sk_root : out_root;
  assign sqout.clamped = sk_v ? sk_clamped : out_clamped;

  `ASSERT_CLK(a_skid_fill, $rose(sk_v) |-> $past(sqout.valid && !sqout.ready), "skid filled without stall")
  `ASSERT_CLK(a_hold_last, sk_v |=> $stable(v[wsr_pkg::LAST_STAGE]), "pipeline moved while skid full")
  `ASSERT_CLK(a_seed_valid, sqin.valid && sqin.ready |=> v[0], "accepted word not in seed stage")
  `ASSERT_NEVER(a_clamp_val, sqout.valid && sqout.clamped && sqout.root != 32'd0 && sqout.root != 32'hFFFFFFFF, "clamped root not at a bound")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams radicand words into the wilkes square root pipeline under random
// idling on both channels and checks each root word against an in-bench
// fixed-point prediction. Includes directed edge values, radicands at and
// above 3.0, a long output stall that backs the pipeline up, and a full drain.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_AT     = 700;
  localparam int HOLD_CYCLES  = 250;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    logic [31:0]     radicand;
    wsr_pkg::root_t  root;
    logic            clamped;
  } root_word_t;

  class root_scoreboard;
    localparam longint ONE_FX   = longint'(1) << wsr_pkg::FRAC_BITS;
    localparam longint THREE_FX = ONE_FX * 3;
    localparam longint FOUR_FX  = ONE_FX * 4;
    localparam longint TOP_FX   = (longint'(1) << 34) - 1;
    localparam longint BOT_FX   = -(longint'(1) << 34);
    localparam bit [63:0] FRAC_MASK_FX = (64'd1 << wsr_pkg::FRAC_BITS) - 1;

    root_word_t due[$];
    int errors;
    int mismatches;
    int radicands;
    int results;
    int clamped_seen;
    int high_radicands;

    function longint clip(longint v);
      if (v > TOP_FX) return TOP_FX;
      if (v < BOT_FX) return BOT_FX;
      return v;
    endfunction

    // truncated sign-magnitude product, saturated to q4.30
    function longint fx_mul(longint x, longint y);
      bit        neg;
      bit [63:0] mx;
      bit [63:0] my;
      bit [63:0] q;
      neg = (x < 0) != (y < 0);
      mx  = (x < 0) ? 64'(-x) : 64'(x);
      my  = (y < 0) ? 64'(-y) : 64'(y);
      q   = (mx >> wsr_pkg::FRAC_BITS) * my +
            (((mx & FRAC_MASK_FX) * my) >> wsr_pkg::FRAC_BITS);
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return clip(neg ? -longint'(q) : longint'(q));
    endfunction

    function root_word_t wilkes_root(logic [31:0] x);
      longint     a;
      longint     b;
      longint     sq;
      longint     qtr;
      root_word_t w;
      a = longint'({32'd0, x});
      b = clip(a - ONE_FX);
      for (int i = 0; i < wsr_pkg::ITERATIONS; i++) begin
        a   = fx_mul(a, clip(ONE_FX - b / 2));
        sq  = fx_mul(b, b);
        qtr = clip(b - THREE_FX) / 4;
        b   = fx_mul(sq, qtr);
      end
      a = fx_mul(a, clip(ONE_FX - b / 2));
      w.radicand = x;
      if (a < 0) begin
        w.root    = '0;
        w.clamped = 1'b1;
      end else if (a >= FOUR_FX) begin
        w.root    = '1;
        w.clamped = 1'b1;
      end else begin
        w.root    = a[31:0];
        w.clamped = 1'b0;
      end
      return w;
    endfunction

    function void note_radicand(logic [31:0] x);
      radicands++;
      if (x >= 32'hC000_0000) high_radicands++;
      due.insert(due.size(), wilkes_root(x));
    endfunction

    function void check_root(wsr_pkg::root_t r, logic c);
      root_word_t w;
      results++;
      if (c === 1'b1) clamped_seen++;
      if (due.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected root word %h clamped %b", r, c);
        mismatches++;
        return;
      end
      w = due.pop_front();
      if (w.root !== r || w.clamped !== c) begin
        errors++;
        if (mismatches < 10)
          $display("mismatch radicand %h: root exp %h got %h, clamped exp %b got %b",
                   w.radicand, w.root, r, w.clamped, c);
        mismatches++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   long_holds;
  int   drains;

  wsr_in_if  in_ch ();
  wsr_out_if out_ch ();

  root_scoreboard sb;

  wilkes_square_root_top dut (
    .clk   (clk),
    .rst   (rst),
    .sqin  (in_ch),
    .sqout (out_ch)
  );

  always #4 clk = ~clk;

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_radicand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 32'hBFFF_FFFF);
    if (r < 65) return $urandom() >> $urandom_range(2, 31);
    if (r < 75) return 32'h4000_0000 + $urandom_range(0, 8191) - 4096;
    if (r < 85) return 32'hBFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
    return $urandom_range(32'hC000_0000, 32'hFFFF_FFFF);
  endfunction

  task automatic offer_radicand(input logic [31:0] x);
    in_ch.valid    <= 1'b1;
    in_ch.radicand <= x;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_radicand(x);
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      in_ch.valid    <= 1'b0;
      in_ch.radicand <= $urandom();
      repeat (n) @(posedge clk);
    end
  endtask

  // sender
  initial begin
    logic [31:0] edge_vals[20];
    edge_vals = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_FFFF,
                  32'h0100_0000, 32'h1000_0000, 32'h3FFF_FFFF, 32'h4000_0000,
                  32'h4000_0001, 32'h8000_0000, 32'h9000_0000, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'hBFFF_FFFE, 32'hBFFF_FFFF, 32'hC000_0000,
                  32'hC000_0001, 32'hE000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    sb             = new();
    long_holds     = 0;
    drains         = 0;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.radicand = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (edge_vals[i]) begin
      idle_input(gap_len());
      offer_radicand(edge_vals[i]);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) begin
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        drains++;
      end else if (((n / 150) % 4) != 1) begin
        idle_input(gap_len());
      end
      offer_radicand(pick_radicand());
    end
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.errors += sb.pending();
    $display("covered %0d radicands (%0d at 3.0 or above), %0d root words, %0d clamped",
             sb.radicands, sb.high_radicands, sb.results, sb.clamped_seen);
    $display("long output holds: %0d, full drains: %0d, mismatches: %0d",
             long_holds, drains, sb.mismatches);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver
  initial begin
    int stall;
    int cyc;
    stall        = 0;
    cyc          = 0;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (out_ch.valid && out_ch.ready) sb.check_root(out_ch.root, out_ch.clamped);
      if (stall == 0 && long_holds < 2 && sb.results >= (long_holds == 0 ? 300 : 1000)) begin
        stall = HOLD_CYCLES;
        long_holds++;
      end else if (stall == 0 && ((cyc / 1200) % 4) != 2 && $urandom_range(0, 3) == 0) begin
        stall = gap_len();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      cyc++;
    end
  end

  // run limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/wsr_pkg.sv
src/wsr_if.sv
src/wilkes_square_root_top.sv
verif/tb_top.sv
